>>> rtl/core/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the preemptive priority scheduler core.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

	localparam int MAX_PROCS = 16;
	localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int TIME_W    = 24;

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic        func;
		logic [7:0]  proc_id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [7:0]  prio;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic              idle;
		logic [7:0]        running_id;
		logic              finished;
		logic [7:0]        finished_id;
		logic [TIME_W-1:0] comp_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
	} result_t;

	typedef struct packed {
		logic [7:0]  proc_id;
		logic [15:0] arrival;
		logic [15:0] burst;
		logic [15:0] remaining;
		logic [7:0]  prio;
		logic [7:0]  order;
	} slot_t;

	typedef struct packed {
		logic capture;
		logic scan_run;
		logic prep;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} ctl_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_PREP,
		ST_COMMIT
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/preemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Preemptive priority scheduler over a table of loaded processes.
// ----------------------------------------------------------------------------
// Each transaction is a load or a tick and yields exactly one result. A load
// stores the process in the lowest free slot, if there is one. A tick scans
// the table one slot per cycle through the single read port of the slot
// memory, keeping the best arrived candidate (smallest priority, then earliest
// arrival, then earliest load). Either waits before its commit while the
// previous result sits unread in the output register. A new transaction is
// taken while a result still waits to be read.
`default_nettype none

module preemptive_priority_scheduler_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_stall,
	input  pps_pkg::item_t     item,
	output logic               result_valid,
	input  wire                result_stall,
	output pps_pkg::result_t   result
);
	import pps_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	pps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_func  (item.func),
		.stat       (stat),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	pps_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.result_stall (result_stall),
		.stat         (stat),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/core/pps_ctrl.sv
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer for the scheduler: takes a transaction, runs the slot scan for a
// tick, waits for the result register and commits the update.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	input  wire                  item_func,
	input  pps_pkg::ctl_stat_t   stat,
	output logic                 item_stall,
	output pps_pkg::ctl_cmd_t    cmd
);
	import pps_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = (item_func == FUNC_TICK) ? ST_SCAN : ST_PREP;
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				if (stat.out_free) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/pps_datapath.sv
// ----------------------------------------------------------------------------
// pps_datapath
// Process table, slot scan with running best, time and load counters, and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_datapath (
	input  wire                  clk,
	input  wire                  arst_n,
	input  pps_pkg::item_t       item,
	input  pps_pkg::ctl_cmd_t    cmd,
	input  wire                  result_stall,
	output pps_pkg::ctl_stat_t   stat,
	output logic                 result_valid,
	output pps_pkg::result_t     result
);
	import pps_pkg::*;

	slot_t              mem [MAX_PROCS];
	logic [MAX_PROCS-1:0] valid_q;

	item_t              item_q;
	logic [SLOT_W-1:0]  scan_idx_q;
	logic               rd_vld_s1;
	logic               rd_slot_vld_s1;
	logic [SLOT_W-1:0]  rd_idx_s1;
	slot_t              rd_s1;

	logic               best_vld_q;
	logic [SLOT_W-1:0]  best_idx_q;
	slot_t              best_q;

	logic [TIME_W-1:0]  time_q;
	logic [TIME_W-1:0]  comp_q;
	logic [16:0]        ab_q;
	logic [7:0]         load_cnt_q;

	logic               out_valid_q;
	result_t            out_q;
	result_t            res;

	logic               free_found;
	logic [SLOT_W-1:0]  free_idx;
	logic               eligible;
	logic               take;
	logic               is_tick;
	logic               done;
	logic               we;
	logic [SLOT_W-1:0]  waddr;
	slot_t              wdata;

	function automatic logic beats(input slot_t a, input slot_t b);
		logic r;
		if (a.prio != b.prio) begin
			r = a.prio < b.prio;
		end else if (a.arrival != b.arrival) begin
			r = a.arrival < b.arrival;
		end else begin
			r = a.order < b.order;
		end
		return r;
	endfunction

	assign is_tick = (item_q.func == FUNC_TICK);
	assign done    = (best_q.remaining <= 16'd1);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = MAX_PROCS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign eligible = rd_vld_s1 && rd_slot_vld_s1
		&& ({8'd0, rd_s1.arrival} <= time_q);
	assign take = eligible && (!best_vld_q || beats(rd_s1, best_q));

	// table write port
	always_comb begin
		we    = 1'b0;
		waddr = free_idx;
		wdata = '0;
		if (cmd.commit) begin
			if (is_tick) begin
				waddr           = best_idx_q;
				wdata           = best_q;
				wdata.remaining = best_q.remaining - 16'd1;
				we              = best_vld_q && !done;
			end else begin
				waddr           = free_idx;
				wdata.proc_id   = item_q.proc_id;
				wdata.arrival   = item_q.arrival;
				wdata.burst     = item_q.burst;
				wdata.remaining = item_q.burst;
				wdata.prio      = item_q.prio;
				wdata.order     = load_cnt_q;
				we              = free_found;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[scan_idx_q];
	end

	// result of the transaction in progress
	always_comb begin
		res          = '0;
		res.accepted = is_tick || free_found;
		if (is_tick) begin
			if (!best_vld_q) begin
				res.idle = 1'b1;
			end else begin
				res.running_id = best_q.proc_id;
				if (done) begin
					res.finished    = 1'b1;
					res.finished_id = best_q.proc_id;
					res.comp_time   = comp_q;
					res.turnaround  = comp_q - {8'd0, best_q.arrival};
					res.waiting     = (comp_q > {7'd0, ab_q})
						? comp_q - {7'd0, ab_q} : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		rd_idx_s1 <= scan_idx_q;
		if (take) begin
			best_idx_q <= rd_idx_s1;
			best_q     <= rd_s1;
		end
		if (cmd.prep) begin
			comp_q <= (time_q < TIME_MAX) ? time_q + 1'b1 : TIME_MAX;
			ab_q   <= {1'b0, best_q.arrival} + {1'b0, best_q.burst};
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			scan_idx_q     <= '0;
			rd_vld_s1      <= 1'b0;
			rd_slot_vld_s1 <= 1'b0;
			best_vld_q     <= 1'b0;
			time_q         <= '0;
			load_cnt_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			rd_vld_s1      <= cmd.scan_run;
			rd_slot_vld_s1 <= valid_q[scan_idx_q];
			if (cmd.capture) begin
				scan_idx_q <= '0;
				best_vld_q <= 1'b0;
			end else begin
				if (cmd.scan_run) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
				if (take) begin
					best_vld_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (is_tick) begin
					time_q <= comp_q;
					if (best_vld_q && done) begin
						valid_q[best_idx_q] <= 1'b0;
					end
				end else if (free_found) begin
					valid_q[free_idx] <= 1'b1;
					load_cnt_q        <= load_cnt_q + 8'd1;
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.scan_last = (scan_idx_q == SLOT_W'(MAX_PROCS - 1));
	assign stat.out_free  = !out_valid_q || !result_stall;
	assign result_valid   = out_valid_q;
	assign result         = out_q;

`ifndef SYNTHESIS
	a_commit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !out_valid_q)
		else $error("result register overwritten");
	a_winner_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && is_tick && best_vld_q |-> valid_q[best_idx_q])
		else $error("winner slot not occupied");
	a_time_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> time_q >= $past(time_q))
		else $error("time went backward");
	a_cnt_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(load_cnt_q) |-> $past(cmd.commit))
		else $error("load counter moved outside commit");
`endif

endmodule

`default_nettype wire
